>>> rtl/rfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfl_pkg
// Widths, payload types and inter-stage bundles for the 4D reflection pipe.
// ----------------------------------------------------------------------------
package rfl_pkg;

    localparam int CW  = 32;          // component width
    localparam int PW  = 2 * CW;      // one product
    localparam int DW  = 2 * CW + 2;  // signed dot product v.n
    localparam int QSW = 2 * CW + 1;  // n.n
    localparam int AW  = 2 * CW + 1;  // |v.n|
    localparam int DVW = 2 * CW + 2;  // divisor 2*(n.n)
    localparam int MGW = 3 * CW;      // |n_i * (v.n)|
    localparam int NMW = 3 * CW + 2;  // rounding numerator
    localparam int QW  = CW + 2;      // quotient magnitude
    localparam int FW  = CW + 4;      // pre-saturation result

    typedef logic signed [CW-1:0] comp_t;
    typedef logic [3:0][CW-1:0]   vec4_t;

    typedef struct packed {
        comp_t incident_x;
        comp_t incident_y;
        comp_t incident_z;
        comp_t incident_w;
        comp_t normal_x;
        comp_t normal_y;
        comp_t normal_z;
        comp_t normal_w;
    } in_t;

    typedef struct packed {
        comp_t reflected_x;
        comp_t reflected_y;
        comp_t reflected_z;
        comp_t reflected_w;
        logic  zero_normal;
        logic  saturated;
    } out_t;

    typedef struct packed {
        vec4_t                 v;
        vec4_t                 n;
        logic signed [DW-1:0]  d;
        logic [QSW-1:0]        q;
    } dot_t;

    typedef struct packed {
        vec4_t                 v;
        logic [3:0][NMW-1:0]   num;
        logic [3:0]            neg;
        logic [DVW-1:0]        dvs;
        logic                  zero;
    } scl_t;

    typedef struct packed {
        vec4_t                 v;
        logic [3:0][QW-1:0]    quo;
        logic [3:0]            neg;
        logic                  zero;
    } quo_t;

endpackage

>>> rtl/rfl_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfl_dot
// Two stages: per-lane products v*n and n*n, then the two 4-way sums.
// ----------------------------------------------------------------------------
module rfl_dot
    import rfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_vld,
    input  in_t  din,
    output logic dout_vld,
    output dot_t dout
);

    vec4_t                v_in;
    vec4_t                n_in;
    logic [1:0]           vld_reg;
    vec4_t                v1_reg;
    vec4_t                n1_reg;
    logic signed [PW-1:0] vn_next [4];
    logic signed [PW-1:0] nn_next [4];
    logic signed [PW-1:0] vn_reg  [4];
    logic signed [PW-1:0] nn_reg  [4];
    logic signed [DW-1:0] qsum;
    dot_t                 d2_next;
    dot_t                 d2_reg;

    assign v_in = {din.incident_w, din.incident_z, din.incident_y, din.incident_x};
    assign n_in = {din.normal_w, din.normal_z, din.normal_y, din.normal_x};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vn_next[i] = $signed(v_in[i]) * $signed(n_in[i]);
            nn_next[i] = $signed(n_in[i]) * $signed(n_in[i]);
        end
    end

    always_comb
    begin
        qsum      = DW'(nn_reg[0]) + DW'(nn_reg[1]) + DW'(nn_reg[2]) + DW'(nn_reg[3]);
        d2_next.v = v1_reg;
        d2_next.n = n1_reg;
        d2_next.d = DW'(vn_reg[0]) + DW'(vn_reg[1]) + DW'(vn_reg[2]) + DW'(vn_reg[3]);
        d2_next.q = qsum[QSW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[0], din_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg <= v_in;
            n1_reg <= n_in;
            for (int i = 0; i < 4; i++)
            begin
                vn_reg[i] <= vn_next[i];
                nn_reg[i] <= nn_next[i];
            end
            d2_reg <= d2_next;
        end
    end

    assign dout_vld = vld_reg[1];
    assign dout     = d2_reg;

endmodule

>>> rtl/rfl_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfl_scale
// Four stages: magnitudes, signs and divisor 2*q, split products |n_i|*|d|,
// product merge, then the rounding numerator 4*|n_i*d| + q.
// ----------------------------------------------------------------------------
module rfl_scale
    import rfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_vld,
    input  dot_t din,
    output logic dout_vld,
    output scl_t dout
);

    typedef struct packed {
        vec4_t              v;
        logic [QSW-1:0]     q;
        logic [DVW-1:0]     dvs;
        logic               zero;
        logic [3:0]         neg;
        logic [AW-1:0]      dabs;
        logic [3:0][CW-1:0] nabs;
    } s3_t;

    typedef struct packed {
        vec4_t                v;
        logic [QSW-1:0]       q;
        logic [DVW-1:0]       dvs;
        logic                 zero;
        logic [3:0]           neg;
        logic [3:0][2*CW-1:0] plo;
        logic [3:0][2*CW:0]   phi;
    } s4_t;

    typedef struct packed {
        vec4_t               v;
        logic [QSW-1:0]      q;
        logic [DVW-1:0]      dvs;
        logic                zero;
        logic [3:0]          neg;
        logic [3:0][MGW-1:0] mag;
    } s5_t;

    logic [3:0]    vld_reg;
    logic          dneg;
    logic [DW-1:0] dmag;
    s3_t           s3_next;
    s3_t           s3_reg;
    s4_t           s4_next;
    s4_t           s4_reg;
    s5_t           s5_next;
    s5_t           s5_reg;
    scl_t          s6_next;
    scl_t          s6_reg;

    always_comb
    begin
        dneg         = din.d[DW-1];
        dmag         = dneg ? (~din.d) + DW'(1) : din.d;
        s3_next.v    = din.v;
        s3_next.q    = din.q;
        s3_next.dvs  = {din.q, 1'b0};
        s3_next.zero = (din.q == '0);
        s3_next.dabs = dmag[AW-1:0];
        for (int i = 0; i < 4; i++)
        begin
            s3_next.neg[i]  = din.n[i][CW-1] ^ dneg;
            s3_next.nabs[i] = din.n[i][CW-1] ? (~din.n[i]) + CW'(1) : din.n[i];
        end
    end

    always_comb
    begin
        s4_next.v    = s3_reg.v;
        s4_next.q    = s3_reg.q;
        s4_next.dvs  = s3_reg.dvs;
        s4_next.zero = s3_reg.zero;
        s4_next.neg  = s3_reg.neg;
        for (int i = 0; i < 4; i++)
        begin
            s4_next.plo[i] = s3_reg.nabs[i] * s3_reg.dabs[CW-1:0];
            s4_next.phi[i] = s3_reg.nabs[i] * s3_reg.dabs[AW-1:CW];
        end
    end

    always_comb
    begin
        s5_next.v    = s4_reg.v;
        s5_next.q    = s4_reg.q;
        s5_next.dvs  = s4_reg.dvs;
        s5_next.zero = s4_reg.zero;
        s5_next.neg  = s4_reg.neg;
        for (int i = 0; i < 4; i++)
        begin
            s5_next.mag[i] = MGW'({s4_reg.phi[i], {CW{1'b0}}}) + MGW'(s4_reg.plo[i]);
        end
    end

    always_comb
    begin
        s6_next.v    = s5_reg.v;
        s6_next.dvs  = s5_reg.dvs;
        s6_next.zero = s5_reg.zero;
        s6_next.neg  = s5_reg.neg;
        for (int i = 0; i < 4; i++)
        begin
            s6_next.num[i] = {s5_reg.mag[i], 2'b00} + NMW'(s5_reg.q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], din_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign dout_vld = vld_reg[3];
    assign dout     = s6_reg;

endmodule

>>> rtl/rfl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfl_div
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage (QW stages). Quotient is round(|p|/q) via (2|p|+q)/(2q).
// ----------------------------------------------------------------------------
module rfl_div
    import rfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_vld,
    input  scl_t din,
    output logic dout_vld,
    output quo_t dout
);

    typedef struct packed {
        vec4_t               v;
        logic [3:0]          neg;
        logic                zero;
        logic [DVW-1:0]      dvs;
        logic [3:0][DVW-1:0] rem;
        logic [3:0][QW-1:0]  quo;
        logic [3:0][QW-1:0]  low;
    } div_t;

    function automatic div_t div_step(input div_t a);
        div_t         r;
        logic [DVW:0] t;
        logic         ge;
        r = a;
        for (int i = 0; i < 4; i++)
        begin
            t          = {a.rem[i], a.low[i][QW-1]};
            ge         = (t >= {1'b0, a.dvs});
            r.rem[i]   = ge ? DVW'(t - {1'b0, a.dvs}) : t[DVW-1:0];
            r.quo[i]   = {a.quo[i][QW-2:0], ge};
            r.low[i]   = {a.low[i][QW-2:0], 1'b0};
        end
        return r;
    endfunction

    div_t        init;
    div_t        st_in   [QW];
    div_t        st_next [QW];
    div_t        st_reg  [QW];
    logic [QW-1:0] vld_reg;

    always_comb
    begin
        init.v    = din.v;
        init.neg  = din.neg;
        init.zero = din.zero;
        init.dvs  = din.dvs;
        for (int i = 0; i < 4; i++)
        begin
            init.rem[i] = DVW'(din.num[i][NMW-1:QW]);
            init.quo[i] = '0;
            init.low[i] = din.num[i][QW-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                assign st_in[k] = init;
            end
            else
            begin : g_rest
                assign st_in[k] = st_reg[k-1];
            end

            assign st_next[k] = div_step(st_in[k]);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QW-2:0], din_vld};
        end
    end

    assign dout_vld  = vld_reg[QW-1];
    assign dout.v    = st_reg[QW-1].v;
    assign dout.quo  = st_reg[QW-1].quo;
    assign dout.neg  = st_reg[QW-1].neg;
    assign dout.zero = st_reg[QW-1].zero;

endmodule

>>> rtl/rfl_fix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfl_fix
// Three stages: apply quotient sign, subtract incident, saturate and
// register the result beat.
// ----------------------------------------------------------------------------
module rfl_fix
    import rfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_vld,
    input  quo_t din,
    output logic dout_vld,
    output out_t dout
);

    localparam logic signed [FW-1:0] HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [FW-1:0] LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam comp_t                CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam comp_t                CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        vec4_t              v;
        logic [3:0][QW:0]   sq;
        logic               zero;
    } sa_t;

    typedef struct packed {
        logic [3:0][FW-1:0] r;
        logic               zero;
    } sb_t;

    logic [2:0] vld_reg;
    sa_t        sa_next;
    sa_t        sa_reg;
    sb_t        sb_next;
    sb_t        sb_reg;
    out_t       out_next;
    out_t       out_reg;
    comp_t      res   [4];
    logic [3:0] clip;

    always_comb
    begin
        sa_next.v    = din.v;
        sa_next.zero = din.zero;
        for (int i = 0; i < 4; i++)
        begin
            sa_next.sq[i] = din.neg[i] ? (~{1'b0, din.quo[i]}) + (QW+1)'(1)
                                       : {1'b0, din.quo[i]};
        end
    end

    always_comb
    begin
        sb_next.zero = sa_reg.zero;
        for (int i = 0; i < 4; i++)
        begin
            sb_next.r[i] = FW'($signed(sa_reg.sq[i])) - FW'($signed(sa_reg.v[i]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if ($signed(sb_reg.r[i]) > HI)
            begin
                res[i]  = CMAX;
                clip[i] = 1'b1;
            end
            else if ($signed(sb_reg.r[i]) < LO)
            begin
                res[i]  = CMIN;
                clip[i] = 1'b1;
            end
            else
            begin
                res[i]  = sb_reg.r[i][CW-1:0];
                clip[i] = 1'b0;
            end
        end
        if (sb_reg.zero)
        begin
            out_next = '0;
            out_next.zero_normal = 1'b1;
        end
        else
        begin
            out_next.reflected_x = res[0];
            out_next.reflected_y = res[1];
            out_next.reflected_z = res[2];
            out_next.reflected_w = res[3];
            out_next.zero_normal = 1'b0;
            out_next.saturated   = |clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], din_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            out_reg <= out_next;
        end
    end

    assign dout_vld = vld_reg[2];
    assign dout     = out_reg;

endmodule

>>> rtl/vector_reflection_4d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_reflection_4d
// Pipe order from vec beat to refl beat: dot, scale, divide, fix.
// Throughput: one beat per cycle unless stalled; the bit-per-stage divider
// sets the depth. The whole pipe holds when the output beat is not taken.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module vector_reflection_4d
    import rfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vec_valid,
    output logic vec_ready,
    input  in_t  vec,
    output logic refl_valid,
    input  logic refl_ready,
    output out_t refl
);

    logic adv;
    logic dot_vld;
    dot_t dot_data;
    logic scl_vld;
    scl_t scl_data;
    logic quo_vld;
    quo_t quo_data;

    assign adv       = !refl_valid || refl_ready;
    assign vec_ready = adv;

    rfl_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din_vld  (vec_valid),
        .din      (vec),
        .dout_vld (dot_vld),
        .dout     (dot_data)
    );

    rfl_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din_vld  (dot_vld),
        .din      (dot_data),
        .dout_vld (scl_vld),
        .dout     (scl_data)
    );

    rfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din_vld  (scl_vld),
        .din      (scl_data),
        .dout_vld (quo_vld),
        .dout     (quo_data)
    );

    rfl_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din_vld  (quo_vld),
        .din      (quo_data),
        .dout_vld (refl_valid),
        .dout     (refl)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vector_reflection_4d. Directed and random vector
// pairs are driven with bursty valid and a patterned ready on the result
// side. A scoreboard predicts each reflection with wide exact arithmetic; the bench
// compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import rfl_pkg::*;

    class reflect_board;
        out_t pending[$];
        int   noted;
        int   zero_cnt;
        int   sat_cnt;

        function automatic out_t reflect(in_t a);
            logic signed [199:0] v[4];
            logic signed [199:0] n[4];
            logic signed [199:0] d;
            logic signed [199:0] q;
            logic signed [199:0] p;
            logic signed [199:0] t;
            logic signed [199:0] r;
            logic signed [199:0] hi;
            logic signed [199:0] lo;
            logic [199:0] mag;
            logic [199:0] quo;
            logic [CW-1:0] res[4];
            out_t o;
            bit sat;
            v[0] = a.incident_x; v[1] = a.incident_y;
            v[2] = a.incident_z; v[3] = a.incident_w;
            n[0] = a.normal_x;   n[1] = a.normal_y;
            n[2] = a.normal_z;   n[3] = a.normal_w;
            hi = (200'sd1 <<< (CW - 1)) - 200'sd1;
            lo = -hi - 200'sd1;
            d = 0;
            q = 0;
            sat = 0;
            for (int i = 0; i < 4; i++)
            begin
                d = d + v[i] * n[i];
                q = q + n[i] * n[i];
            end
            o = '0;
            if (q == 0)
            begin
                o.zero_normal = 1'b1;
                return o;
            end
            for (int i = 0; i < 4; i++)
            begin
                p = 200'sd2 * n[i] * d;
                mag = (p < 0) ? -p : p;
                quo = (2 * mag + q) / (2 * q);
                t = (p < 0) ? -$signed(quo) : $signed(quo);
                r = t - v[i];
                if (r > hi)
                begin
                    r = hi;
                    sat = 1;
                end
                if (r < lo)
                begin
                    r = lo;
                    sat = 1;
                end
                res[i] = r[CW-1:0];
            end
            o.reflected_x = res[0];
            o.reflected_y = res[1];
            o.reflected_z = res[2];
            o.reflected_w = res[3];
            o.saturated   = sat;
            return o;
        endfunction

        function void note(in_t a);
            out_t e;
            e = reflect(a);
            pending.push_back(e);
            noted++;
            if (e.zero_normal) zero_cnt++;
            if (e.saturated) sat_cnt++;
        endfunction

        function bit check(out_t got, output out_t exp);
            if (pending.size() == 0) return 0;
            exp = pending.pop_front();
            return 1;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic vec_valid = 0;
    logic vec_ready;
    in_t  vec = '0;
    logic refl_valid;
    logic refl_ready = 0;
    out_t refl;

    reflect_board board = new();
    int   errors = 0;
    int   results = 0;
    bit   stim_done = 0;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = 32'h0001_0000;

    vector_reflection_4d dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_ready  (vec_ready),
        .vec        (vec),
        .refl_valid (refl_valid),
        .refl_ready (refl_ready),
        .refl       (refl)
    );

    always #4 clk = ~clk;

    task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] exp);
        errors++;
        $display("MISMATCH %s: got %h exp %h at %0t", what, got, exp, $realtime);
    endtask

    always @(posedge clk)
    begin
        out_t exp;
        if (rst_n && vec_valid && vec_ready) board.note(vec);
        if (rst_n && refl_valid && refl_ready)
        begin
            results++;
            if (!board.check(refl, exp))
                report("unexpected beat", refl[CW-1:0], '0);
            else
            begin
                if (refl.reflected_x !== exp.reflected_x)
                    report("reflected_x", refl.reflected_x, exp.reflected_x);
                if (refl.reflected_y !== exp.reflected_y)
                    report("reflected_y", refl.reflected_y, exp.reflected_y);
                if (refl.reflected_z !== exp.reflected_z)
                    report("reflected_z", refl.reflected_z, exp.reflected_z);
                if (refl.reflected_w !== exp.reflected_w)
                    report("reflected_w", refl.reflected_w, exp.reflected_w);
                if (refl.zero_normal !== exp.zero_normal)
                    report("zero_normal", refl.zero_normal, exp.zero_normal);
                if (refl.saturated !== exp.saturated)
                    report("saturated", refl.saturated, exp.saturated);
            end
        end
    end

    // receiver stall pattern: the mode is redrawn at random periodically
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (cyc % 64 == 0) mode = $urandom_range(3);
            case (mode)
                0: refl_ready = 1'b1;
                1: refl_ready = $urandom_range(1);
                2: refl_ready = ((cyc / 8) % 2 == 0);
                default: refl_ready = ($urandom_range(7) == 0);
            endcase
            cyc++;
        end
    end

    int burst_left = 0;

    task automatic send(in_t a);
        if (burst_left == 0)
        begin
            vec_valid = 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        vec = a;
        vec_valid = 1'b1;
        do @(posedge clk); while (!vec_ready);
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom;
            2: return CMAX;
            3: return CMIN;
            4: return '0;
            5: return $urandom_range(0, 1) ? ONE : -ONE;
            6: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic in_t rand_item();
        in_t a;
        a.incident_x = rand_comp(); a.incident_y = rand_comp();
        a.incident_z = rand_comp(); a.incident_w = rand_comp();
        a.normal_x = rand_comp();   a.normal_y = rand_comp();
        a.normal_z = rand_comp();   a.normal_w = rand_comp();
        if ($urandom_range(39) == 0)
            {a.normal_x, a.normal_y, a.normal_z, a.normal_w} = '0;
        if ($urandom_range(3) == 0)
        begin
            a = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end
        return a;
    endfunction

    initial
    begin
        in_t a;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 0});
        send('{0, 0, 0, 0, 0, 0, 0, 0});
        send('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
        send('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
        send('{CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX});
        send('{CMIN, 0, 0, 0, 0, ONE, 0, 0});
        send('{CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 1});
        send('{CMAX, 0, 0, 0, 1, 0, 0, 0});
        send('{CMAX, CMAX, 0, 0, 1, 1, 0, 0});
        send('{1, 0, 0, 0, 1, 1, 0, 0});
        send('{1, 0, 0, 0, 1, 1, 1, 1});
        send('{-1, 0, 0, 0, 1, 1, 1, 1});
        send('{3, 0, 0, 0, 1, 1, 1, 1});
        send('{ONE, -ONE, ONE, -ONE, 1, 2, 3, 4});
        send('{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1, CMIN, 1, 0, 0});
        send('{CMAX, CMIN, 1, -1, 3, 0, 0, 7});
        send('{0, 0, 0, 0, CMIN, CMIN, CMIN, CMIN});
        send('{CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0});
        for (int i = 0; i < 1050; i++)
        begin
            a = rand_item();
            send(a);
        end
        vec_valid = 1'b0;
        stim_done = 1;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d vector pairs, %0d result beats", board.noted, results);
        $display("zero-normal cases %0d, saturated cases %0d", board.zero_cnt, board.sat_cnt);
        if (errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
